// ----- rtl/core/tah_pkg.sv -----
// shared constants for the heron triangle area pipeline
`timescale 1ns / 1ps
package tah_pkg;
    // width of the area result
    localparam int AREA_BITS = 51;
    // operand slice width used by the split multipliers
    localparam int MUL_LIMB = 18;
endpackage

// ----- rtl/core/tah_isqrt.sv -----
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module tah_isqrt #(
    parameter int IW = 68,
    localparam int OW = (IW + 1) / 2
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [IW-1:0] x,
    output logic [OW-1:0] root
);
    localparam int XW  = 2 * OW;
    localparam int RMW = OW + 3;

    logic [XW-1:0]  x_reg    [OW];
    logic [RMW-1:0] rem_reg  [OW];
    logic [OW-1:0]  root_reg [OW];

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic [XW-1:0]  xi;
        logic [RMW-1:0] ri;
        logic [OW-1:0]  qi;
        logic [RMW-1:0] rsh;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign xi = XW'(x);
            assign ri = '0;
            assign qi = '0;
        end else begin : g_next
            assign xi = x_reg[k-1];
            assign ri = rem_reg[k-1];
            assign qi = root_reg[k-1];
        end

        // bring down the next two radicand bits
        assign rsh   = {ri[RMW-3:0], xi[XW-1:XW-2]};
        assign trial = RMW'({qi, 2'b01});
        assign ge    = (rsh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= xi << 2;
                rem_reg[k]  <= ge ? (rsh - trial) : rsh;
                root_reg[k] <= {qi[OW-2:0], ge};
            end
        end
    end

    assign root = root_reg[OW-1];
endmodule

// ----- rtl/core/tah_mul.sv -----
// pipelined wide multiplier built from limb products, three stages
`timescale 1ns / 1ps
module tah_mul #(
    parameter int W = 36
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);
    import tah_pkg::*;

    localparam int L  = MUL_LIMB;
    localparam int N  = (W + L - 1) / L;
    localparam int FW = N * L;
    localparam int PW = 2 * FW;

    logic [FW-1:0]  a_ext;
    logic [FW-1:0]  b_ext;
    logic [2*L-1:0] pp_reg   [N*N];
    logic [PW-1:0]  row_next [N];
    logic [PW-1:0]  row_reg  [N];
    logic [PW-1:0]  p_next;
    logic [PW-1:0]  p_reg;

    assign a_ext = FW'(a);
    assign b_ext = FW'(b);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < N; j++) begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i*N+j]) << (j * L));
            end
        end
        p_next = '0;
        for (int i = 0; i < N; i++) begin
            p_next = p_next + (row_reg[i] << (i * L));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                for (int j = 0; j < N; j++) begin
                    pp_reg[i*N+j] <= (2*L)'(a_ext[i*L +: L]) * (2*L)'(b_ext[j*L +: L]);
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= p_next;
        end
    end

    assign p = p_reg[2*W-1:0];
endmodule

// ----- rtl/core/tah_edge.sv -----
// one edge length: difference, squares, sum, then square root
`timescale 1ns / 1ps
module tah_edge #(
    parameter int COORD_BITS = 24,
    parameter int LEN_FRAC_BITS = 8,
    localparam int LW = (2 * (COORD_BITS + 1) + 2 + 2 * LEN_FRAC_BITS + 1) / 2
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  logic signed [COORD_BITS-1:0] qz,
    output logic [LW-1:0]                len
);
    localparam int CB  = COORD_BITS;
    localparam int SQW = 2 * (CB + 1);
    localparam int SSW = SQW + 2;
    localparam int RW  = SSW + 2 * LEN_FRAC_BITS;

    logic signed [CB:0] d [3];
    logic [CB:0]        mag_reg [3];
    logic [SQW-1:0]     sq_reg  [3];
    logic [SSW-1:0]     sum;
    logic [RW-1:0]      rad_reg;

    assign d[0] = {qx[CB-1], qx} - {px[CB-1], px};
    assign d[1] = {qy[CB-1], qy} - {py[CB-1], py};
    assign d[2] = {qz[CB-1], qz} - {pz[CB-1], pz};

    assign sum = SSW'(sq_reg[0]) + SSW'(sq_reg[1]) + SSW'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= d[i][CB] ? (CB+1)'(-d[i]) : (CB+1)'(d[i]);
                sq_reg[i]  <= SQW'(mag_reg[i]) * SQW'(mag_reg[i]);
            end
            // extra fraction bits for the length
            rad_reg <= RW'(sum) << (2 * LEN_FRAC_BITS);
        end
    end

    tah_isqrt #(.IW(RW)) u_sqrt (
        .aclk (aclk),
        .en   (en),
        .x    (rad_reg),
        .root (len)
    );
endmodule

// ----- rtl/core/triangle_area_heron.sv -----
// top level: triangle area by heron's formula, fully pipelined
// Takes one triangle (three vertices, signed fixed point) per cycle while the
// output is not stalled and returns its area in coordinate LSB squared units,
// truncated and saturated, with a flag for degenerate triangles (area then 0).
// Edge lengths are LW = COORD_BITS + LEN_FRAC_BITS + 2 bits wide. Most of the
// pipeline is the two square-root pipelines, one result bit per stage (edge
// lengths, then the final root); the multipliers add three stages each. A
// stalled result holds the whole pipeline, and s_ready is low only while a
// result waits and m_ready is low.
`timescale 1ns / 1ps
module triangle_area_heron #(
    parameter int COORD_BITS = 24,
    parameter int LEN_FRAC_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_BITS-1:0]    s_ax,
    input  logic signed [COORD_BITS-1:0]    s_ay,
    input  logic signed [COORD_BITS-1:0]    s_az,
    input  logic signed [COORD_BITS-1:0]    s_bx,
    input  logic signed [COORD_BITS-1:0]    s_by_coord,
    input  logic signed [COORD_BITS-1:0]    s_bz,
    input  logic signed [COORD_BITS-1:0]    s_cx,
    input  logic signed [COORD_BITS-1:0]    s_cy,
    input  logic signed [COORD_BITS-1:0]    s_cz,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tah_pkg::AREA_BITS-1:0]   m_area,
    output logic                            m_degenerate
);
    import tah_pkg::*;

    localparam int SQW  = 2 * (COORD_BITS + 1);
    localparam int RW   = SQW + 2 + 2 * LEN_FRAC_BITS;
    localparam int LW   = (RW + 1) / 2;
    localparam int SUMW = LW + 2;
    localparam int TW   = LW + 3;
    localparam int RTW  = 2 * SUMW;
    localparam int PW   = 4 * SUMW;
    localparam int SH   = 2 * LEN_FRAC_BITS + 2;
    localparam int EXTW = (RTW > AREA_BITS) ? RTW : AREA_BITS;
    // flag delay: sum stage, two multiplier levels, final root
    localparam int DG   = 7 + RTW;
    localparam int D    = 3 + LW + DG;

    logic                  en;
    logic [D-1:0]          vld_reg;
    logic [DG-1:0]         dg_reg;
    logic [LW-1:0]         len_a;
    logic [LW-1:0]         len_b;
    logic [LW-1:0]         len_c;
    logic [SUMW-1:0]       s_sum;
    logic signed [TW-1:0]  t2;
    logic signed [TW-1:0]  t3;
    logic signed [TW-1:0]  t4;
    logic                  degen;
    logic [SUMW-1:0]       sum_reg;
    logic [SUMW-1:0]       f2_reg;
    logic [SUMW-1:0]       f3_reg;
    logic [SUMW-1:0]       f4_reg;
    logic [RTW-1:0]        prod_st2;
    logic [RTW-1:0]        prod_t34;
    logic [PW-1:0]         rad;
    logic [RTW-1:0]        root;
    logic [EXTW-1:0]       ext;
    logic                  over;
    logic [AREA_BITS-1:0]  area_next;
    logic                  m_valid_reg;
    logic [AREA_BITS-1:0]  m_area_reg;
    logic                  m_degenerate_reg;

    // whole pipeline advances unless a result is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tah_edge #(.COORD_BITS(COORD_BITS), .LEN_FRAC_BITS(LEN_FRAC_BITS)) u_edge_a (
        .aclk (aclk), .en (en),
        .px (s_ax), .py (s_ay), .pz (s_az),
        .qx (s_bx), .qy (s_by_coord), .qz (s_bz),
        .len (len_a)
    );

    tah_edge #(.COORD_BITS(COORD_BITS), .LEN_FRAC_BITS(LEN_FRAC_BITS)) u_edge_b (
        .aclk (aclk), .en (en),
        .px (s_bx), .py (s_by_coord), .pz (s_bz),
        .qx (s_cx), .qy (s_cy), .qz (s_cz),
        .len (len_b)
    );

    tah_edge #(.COORD_BITS(COORD_BITS), .LEN_FRAC_BITS(LEN_FRAC_BITS)) u_edge_c (
        .aclk (aclk), .en (en),
        .px (s_cx), .py (s_cy), .pz (s_cz),
        .qx (s_ax), .qy (s_ay), .qz (s_az),
        .len (len_c)
    );

    assign s_sum = SUMW'(len_a) + SUMW'(len_b) + SUMW'(len_c);
    assign t2    = TW'(len_b) + TW'(len_c) - TW'(len_a);
    assign t3    = TW'(len_a) + TW'(len_c) - TW'(len_b);
    assign t4    = TW'(len_a) + TW'(len_b) - TW'(len_c);
    assign degen = t2[TW-1] || (t2 == '0) || t3[TW-1] || (t3 == '0)
                || t4[TW-1] || (t4 == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= s_sum;
            f2_reg  <= t2[SUMW-1:0];
            f3_reg  <= t3[SUMW-1:0];
            f4_reg  <= t4[SUMW-1:0];
        end
    end

    tah_mul #(.W(SUMW)) u_mul_st2 (
        .aclk (aclk), .en (en), .a (sum_reg), .b (f2_reg), .p (prod_st2)
    );

    tah_mul #(.W(SUMW)) u_mul_t34 (
        .aclk (aclk), .en (en), .a (f3_reg), .b (f4_reg), .p (prod_t34)
    );

    tah_mul #(.W(RTW)) u_mul_rad (
        .aclk (aclk), .en (en), .a (prod_st2), .b (prod_t34), .p (rad)
    );

    tah_isqrt #(.IW(PW)) u_sqrt (
        .aclk (aclk), .en (en), .x (rad), .root (root)
    );

    assign ext  = EXTW'(root) >> SH;
    assign over = |(ext >> AREA_BITS);

    always_comb begin
        if (dg_reg[DG-1]) begin
            area_next = '0;
        end else if (over) begin
            area_next = '1;
        end else begin
            area_next = ext[AREA_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[D-2:0], s_valid};
            m_valid_reg <= vld_reg[D-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg_reg           <= {dg_reg[DG-2:0], degen};
            m_area_reg       <= area_next;
            m_degenerate_reg <= dg_reg[DG-1];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_area       = m_area_reg;
    assign m_degenerate = m_degenerate_reg;
endmodule

// ----- rtl/core/tah_checker.sv -----
// port-level checks for the triangle area pipeline, bound to the top level
`timescale 1ns / 1ps
module tah_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tah_pkg::AREA_BITS-1:0] m_area,
    input logic                          m_degenerate
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_area) && $stable(m_degenerate))
        else $error("result changed while stalled");

    // degenerate triangles report zero area
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_area == '0)
        else $error("degenerate result with nonzero area");

    // a stalled result holds the input side too
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result stalled");

    // free output means input is open
    a_free_in: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind triangle_area_heron tah_checker u_tah_checker (.*);

// ----- bench/triangle_area_heron_tb.sv -----
// self-checking bench for the heron triangle area pipeline
`timescale 1ns / 1ps
module triangle_area_heron_tb;
    import tah_pkg::*;

    localparam int CB = 24;
    localparam int LFB = 8;
    localparam int N_RANDOM = 600;
    localparam int DRAIN_CYCLES = 140;

    typedef logic signed [CB-1:0] coord_t;
    typedef coord_t tri_t [9];
    typedef logic [255:0] big_t;

    typedef struct {
        logic [AREA_BITS-1:0] area;
        logic                 degenerate;
    } area_res_t;

    class area_scoreboard;
        area_res_t pending_q[$];

        function big_t root_floor(big_t n);
            big_t rem, res, bitv, t;
            rem = n;
            res = '0;
            bitv = big_t'(1) << 254;
            for (int k = 0; k < 128; k++) begin
                t = res + bitv;
                if (rem >= t) begin
                    rem = rem - t;
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function longint edge_length(coord_t p0, coord_t p1, coord_t p2,
                                     coord_t q0, coord_t q1, coord_t q2);
            longint d [3];
            longint m;
            big_t acc;
            d[0] = longint'(q0) - longint'(p0);
            d[1] = longint'(q1) - longint'(p1);
            d[2] = longint'(q2) - longint'(p2);
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? -d[i] : d[i];
                acc = acc + big_t'(m * m);
            end
            acc = root_floor(acc << (2 * LFB));
            return longint'(acc[63:0]);
        endfunction

        function void note_request(tri_t v);
            longint a, b, c, t2, t3, t4;
            big_t r;
            area_res_t e;
            a = edge_length(v[0], v[1], v[2], v[3], v[4], v[5]);
            b = edge_length(v[3], v[4], v[5], v[6], v[7], v[8]);
            c = edge_length(v[6], v[7], v[8], v[0], v[1], v[2]);
            t2 = b + c - a;
            t3 = a + c - b;
            t4 = a + b - c;
            if (t2 <= 0 || t3 <= 0 || t4 <= 0) begin
                e.area = '0;
                e.degenerate = 1'b1;
            end else begin
                r = big_t'(a + b + c) * big_t'(t2) * big_t'(t3) * big_t'(t4);
                r = root_floor(r) >> (2 * LFB + 2);
                if (r >> AREA_BITS != 0) e.area = '1;
                else e.area = r[AREA_BITS-1:0];
                e.degenerate = 1'b0;
            end
            pending_q.push_back(e);
        endfunction

        function bit check_result(logic [AREA_BITS-1:0] area, logic degenerate,
                                  output string msg);
            area_res_t e;
            if (pending_q.size() == 0) begin
                msg = $sformatf("unexpected result area=%0d degenerate=%0b",
                                area, degenerate);
                return 1'b0;
            end
            e = pending_q.pop_front();
            if (area !== e.area || degenerate !== e.degenerate) begin
                msg = $sformatf("area=%0d degenerate=%0b, wanted area=%0d degenerate=%0b",
                                area, degenerate, e.area, e.degenerate);
                return 1'b0;
            end
            msg = "";
            return 1'b1;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    coord_t s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz;
    logic m_valid;
    logic m_ready;
    logic [AREA_BITS-1:0] m_area;
    logic m_degenerate;

    area_scoreboard sb = new();
    int errors = 0;
    bit hold_req = 1'b0;

    triangle_area_heron #(.COORD_BITS(CB), .LEN_FRAC_BITS(LFB)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ax(s_ax), .s_ay(s_ay), .s_az(s_az),
        .s_bx(s_bx), .s_by_coord(s_by_coord), .s_bz(s_bz),
        .s_cx(s_cx), .s_cy(s_cy), .s_cz(s_cz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_area(m_area), .m_degenerate(m_degenerate)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // one request; valid is left high so the next one can follow back to back
    task automatic send_tri(tri_t v);
        s_valid <= 1'b1;
        s_ax <= v[0]; s_ay <= v[1]; s_az <= v[2];
        s_bx <= v[3]; s_by_coord <= v[4]; s_bz <= v[5];
        s_cx <= v[6]; s_cy <= v[7]; s_cz <= v[8];
        do @(posedge aclk); while (!s_ready);
        sb.note_request(v);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord(int kind);
        case (kind)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(2047) - 1024);
            default: begin
                case ($urandom_range(4))
                    0: return {1'b1, {(CB-1){1'b0}}};
                    1: return {1'b0, {(CB-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return coord_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic tri_t random_tri();
        tri_t v;
        int kind, base, step, mult;
        kind = $urandom_range(9);
        if (kind < 5) begin
            foreach (v[i]) v[i] = pick_coord(0);
        end else if (kind < 7) begin
            foreach (v[i]) v[i] = pick_coord(1);
        end else if (kind == 7) begin
            // collinear: c = a + k*(b-a)
            mult = $urandom_range(5) - 2;
            for (int i = 0; i < 3; i++) begin
                base = $urandom_range(2000000) - 1000000;
                step = $urandom_range(400000) - 200000;
                v[i] = coord_t'(base);
                v[3+i] = coord_t'(base + step);
                v[6+i] = coord_t'(base + mult * step);
            end
        end else if (kind == 8) begin
            // two or three coincident vertices
            foreach (v[i]) v[i] = pick_coord(0);
            for (int i = 0; i < 3; i++) v[3+i] = v[i];
            if ($urandom_range(1)) for (int i = 0; i < 3; i++) v[6+i] = v[i];
        end else begin
            foreach (v[i]) v[i] = pick_coord(2);
        end
        return v;
    endfunction

    // receiver: shifting stall pattern, plus one long hold-off on request
    always @(posedge aclk) begin
        string msg;
        static int mode_left = 0;
        static int mode = 0;
        static int hold_left = 0;
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_result(m_area, m_degenerate, msg)) report(msg);
        end
        if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (mode_left == 0) begin
            mode = $urandom_range(3);
            mode_left = $urandom_range(200, 20);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3) != 0);
                2: m_ready <= ($urandom_range(3) == 0);
                default: m_ready <= ((mode_left % 8) < 5);
            endcase
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL triangle_area_heron");
        $finish;
    end

    initial begin
        tri_t v;
        coord_t mn, mx;
        int burst;
        mn = {1'b1, {(CB-1){1'b0}}};
        mx = {1'b0, {(CB-1){1'b1}}};
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        {s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz} = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all coincident at origin
        v = '{default: '0};
        send_tri(v);
        // widest spread on every axis
        v = '{mn, mn, mn, mx, mx, mx, mn, mx, mn};
        send_tri(v);
        v = '{mx, mn, mn, mn, mx, mn, mn, mn, mx};
        send_tri(v);
        v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
        send_tri(v);
        v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
        send_tri(v);
        // unit right triangle in the lsb grid
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_tri(v);
        // 3-4-5 right triangle in q8.16 units
        v = '{0, 0, 0, 24'sd196608, 0, 0, 0, 24'sd262144, 0};
        send_tri(v);
        // collinear along a diagonal
        v = '{-100, -100, -100, 0, 0, 0, 100, 100, 100};
        send_tri(v);
        // collinear spanning the full range
        v = '{mn, 0, 0, 0, 0, 0, mx, 0, 0};
        send_tri(v);
        // two coincident vertices
        v = '{5, 7, 9, 5, 7, 9, -3, 2, 8};
        send_tri(v);
        // needle thin: length rounding at the edge of degeneracy
        v = '{0, 0, 0, mx, 0, 0, 0, 1, 0};
        send_tri(v);
        v = '{mn, mn, mn, mx, mx, mx, 0, 0, 1};
        send_tri(v);
        // all ones and alternating patterns, then assorted values
        v = '{'1, '1, '1, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, '1};
        send_tri(v);
        v = '{24'h123456, -24'sd654321, 24'h0f0f0f, -24'sd1, 24'h7f0000, 24'h800001,
              24'h00ffff, 24'hff0000, 24'h010101};
        send_tri(v);
        idle_sender(3);

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(40, 1);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                if (n == 200) hold_req = 1'b1;
                if (n == 450) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (sb.pending() != 0);
                end
                send_tri(random_tri());
            end
            if ($urandom_range(3) != 0) idle_sender($urandom_range(8, 1));
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS triangle_area_heron");
        end else begin
            $display("FAIL triangle_area_heron");
        end
        $finish;
    end
endmodule
